>>> rtl/pdsc_pkg.sv
// Shared types, constants and arithmetic helpers for the pgroup downscale block.
`timescale 1ns / 1ps

package pdsc_pkg;

    localparam int DIM_W          = 14;
    localparam int POS_W          = 13;
    localparam int SMP_W          = 10;
    localparam int CHAN_W         = 8;
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_W         = 18;
    localparam int DIFF_W         = SMP_W + 1;
    localparam int PROD_W         = COEF_W + DIFF_W;
    localparam int ACC_W          = PROD_W + 1;

    localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(8192);

    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CW    = $clog2(OFIFO_DEPTH + 1);

    // Q16 coefficients, round half up
    localparam longint KY_L  = ((64'd255 << (COEF_FRAC_BITS + 1)) + 64'd876) / 64'd1752;
    localparam longint KR_L  = ((64'd4015740 << (COEF_FRAC_BITS + 1)) + 64'd8960000)
                               / 64'd17920000;
    localparam longint KGB_L = ((64'd477615 << (COEF_FRAC_BITS + 1)) + 64'd8960000)
                               / 64'd17920000;
    localparam longint KGR_L = ((64'd1193655 << (COEF_FRAC_BITS + 1)) + 64'd8960000)
                               / 64'd17920000;
    localparam longint KB_L  = ((64'd4731780 << (COEF_FRAC_BITS + 1)) + 64'd8960000)
                               / 64'd17920000;

    localparam logic signed [COEF_W-1:0] KY  = COEF_W'(KY_L);
    localparam logic signed [COEF_W-1:0] KR  = COEF_W'(KR_L);
    localparam logic signed [COEF_W-1:0] KGB = COEF_W'(KGB_L);
    localparam logic signed [COEF_W-1:0] KGR = COEF_W'(KGR_L);
    localparam logic signed [COEF_W-1:0] KB  = COEF_W'(KB_L);

    localparam logic signed [DIFF_W-1:0] Y_OFFSET = DIFF_W'(64);
    localparam logic signed [DIFF_W-1:0] C_OFFSET = DIFF_W'(512);

    typedef enum logic [1:0] {
        REG_SRC_WIDTH    = 2'd0,
        REG_SRC_HEIGHT   = 2'd1,
        REG_THUMB_WIDTH  = 2'd2,
        REG_THUMB_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic             busy;
        logic [DIM_W-1:0] sw;
        logic [DIM_W-1:0] sh;
        logic [DIM_W-1:0] tw;
        logic [DIM_W-1:0] th;
        logic [DIM_W-1:0] col_q;
        logic [DIM_W-1:0] col_r;
        logic [DIM_W-1:0] row_q;
        logic [DIM_W-1:0] row_r;
    } geom_t;

    typedef struct packed {
        logic [1:0]       pick;
        logic [POS_W-1:0] tcol0;
        logic [POS_W-1:0] tcol1;
        logic [POS_W-1:0] trow;
        logic [1:0]       done;
    } pick_t;

    typedef struct packed {
        logic [DIM_W-1:0] pick;
        logic [DIM_W-1:0] rem;
    } adv_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [POS_W-1:0]  thumb_col;
        logic [POS_W-1:0]  thumb_row;
        logic              last_of_run;
        logic              frame_done;
    } result_t;

    // quotient plus remainder step of a nearest-neighbour target
    function automatic adv_t advance(input logic [DIM_W-1:0] pick,
                                     input logic [DIM_W-1:0] rem,
                                     input logic [DIM_W-1:0] q,
                                     input logic [DIM_W-1:0] r,
                                     input logic [DIM_W-1:0] den);
        logic [DIM_W:0] sum;
        adv_t           a;
        sum = {1'b0, rem} + {1'b0, r};
        if (sum >= {1'b0, den})
        begin
            a.rem  = DIM_W'(sum - {1'b0, den});
            a.pick = pick + q + DIM_W'(1);
        end
        else
        begin
            a.rem  = DIM_W'(sum);
            a.pick = pick + q;
        end
        return a;
    endfunction

    // round half up, clamp to 0..255
    function automatic logic [CHAN_W-1:0] to_8bit(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0] s;
        logic [CHAN_W-1:0]     v;
        s = (ACC_W+1)'(acc) + (ACC_W+1)'(1 << (COEF_FRAC_BITS - 1));
        if (s[ACC_W])
            v = '0;
        else if (s[ACC_W-1:COEF_FRAC_BITS] > (ACC_W-COEF_FRAC_BITS)'(255))
            v = '1;
        else
            v = s[COEF_FRAC_BITS +: CHAN_W];
        return v;
    endfunction

endpackage

>>> rtl/pdsc_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module pdsc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pdsc_pkg::DIM_W-1:0] num,
    input  logic [pdsc_pkg::DIM_W-1:0] den,
    output logic                       busy,
    output logic [pdsc_pkg::DIM_W-1:0] quo,
    output logic [pdsc_pkg::DIM_W-1:0] rem
);
    import pdsc_pkg::*;

    localparam int CNT_W = $clog2(DIM_W);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIM_W-1:0] quo_reg;
    logic [DIM_W-1:0] rem_reg;
    logic [DIM_W-1:0] den_reg;
    logic [DIM_W:0]   trial;

    assign trial = {rem_reg, quo_reg[DIM_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIM_W - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= DIM_W'(trial - {1'b0, den_reg});
                quo_reg <= {quo_reg[DIM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= DIM_W'(trial);
                quo_reg <= {quo_reg[DIM_W-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

>>> rtl/pdsc_cfg.sv
// Configuration registers, size clamping and scale step division.
`timescale 1ns / 1ps

module pdsc_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [pdsc_pkg::DIM_W-1:0] cfg_data,
    output pdsc_pkg::geom_t            geom
);
    import pdsc_pkg::*;

    logic [DIM_W-1:0] src_width_reg;
    logic [DIM_W-1:0] src_height_reg;
    logic [DIM_W-1:0] thumb_width_reg;
    logic [DIM_W-1:0] thumb_height_reg;
    logic             dirty_reg;
    logic [DIM_W-1:0] sw_reg, sh_reg, tw_reg, th_reg;
    logic [DIM_W-1:0] sw_next, sh_next, tw_next, th_next;
    logic [DIM_W-1:0] sw_clamp;
    logic             wr;
    logic             start;
    logic             col_busy, row_busy;
    logic [DIM_W-1:0] col_q, col_r, row_q, row_r;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid & cfg_ready;
    assign start     = dirty_reg & ~col_busy & ~row_busy;

    always_comb
    begin
        if (src_width_reg < DIM_W'(2))
            sw_clamp = DIM_W'(2);
        else if (src_width_reg > MAX_DIM)
            sw_clamp = MAX_DIM;
        else
            sw_clamp = src_width_reg;
        sw_next = {sw_clamp[DIM_W-1:1], 1'b0};

        if (src_height_reg == '0)
            sh_next = DIM_W'(1);
        else if (src_height_reg > MAX_DIM)
            sh_next = MAX_DIM;
        else
            sh_next = src_height_reg;

        if (thumb_width_reg == '0)
            tw_next = DIM_W'(1);
        else if (thumb_width_reg > sw_next)
            tw_next = sw_next;
        else
            tw_next = thumb_width_reg;

        if (thumb_height_reg == '0)
            th_next = DIM_W'(1);
        else if (thumb_height_reg > sh_next)
            th_next = sh_next;
        else
            th_next = thumb_height_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg    <= DIM_W'(1920);
            src_height_reg   <= DIM_W'(1080);
            thumb_width_reg  <= DIM_W'(320);
            thumb_height_reg <= DIM_W'(180);
            dirty_reg        <= 1'b1;
        end
        else
        begin
            if (wr)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_SRC_WIDTH:    src_width_reg    <= cfg_data;
                    REG_SRC_HEIGHT:   src_height_reg   <= cfg_data;
                    REG_THUMB_WIDTH:  thumb_width_reg  <= cfg_data;
                    REG_THUMB_HEIGHT: thumb_height_reg <= cfg_data;
                    default:          ;
                endcase
            end
            if (wr)
                dirty_reg <= 1'b1;
            else if (start)
                dirty_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sw_reg <= sw_next;
            sh_reg <= sh_next;
            tw_reg <= tw_next;
            th_reg <= th_next;
        end
    end

    pdsc_div u_col_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .num   (sw_next),
        .den   (tw_next),
        .busy  (col_busy),
        .quo   (col_q),
        .rem   (col_r)
    );

    pdsc_div u_row_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .num   (sh_next),
        .den   (th_next),
        .busy  (row_busy),
        .quo   (row_q),
        .rem   (row_r)
    );

    always_comb
    begin
        geom.busy  = dirty_reg | col_busy | row_busy;
        geom.sw    = sw_reg;
        geom.sh    = sh_reg;
        geom.tw    = tw_reg;
        geom.th    = th_reg;
        geom.col_q = col_q;
        geom.col_r = col_r;
        geom.row_q = row_q;
        geom.row_r = row_r;
    end

endmodule

>>> rtl/pdsc_pick.sv
// Source position counters and nearest-neighbour pixel selection.
`timescale 1ns / 1ps

module pdsc_pick (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic            frame_start,
    input  pdsc_pkg::geom_t geom,
    output pdsc_pkg::pick_t info
);
    import pdsc_pkg::*;

    logic [DIM_W-1:0] source_col_reg, source_row_reg, target_col_reg, target_row_reg;
    logic [DIM_W-1:0] next_pick_col_reg, col_remainder_reg;
    logic [DIM_W-1:0] next_pick_row_reg, row_remainder_reg;

    logic [DIM_W-1:0] source_col_next, source_row_next, target_col_next, target_row_next;
    logic [DIM_W-1:0] next_pick_col_next, col_remainder_next;
    logic [DIM_W-1:0] next_pick_row_next, row_remainder_next;

    logic [DIM_W-1:0] sc, sr, tc, tr, npc, crem, npr, rrem;
    logic [DIM_W-1:0] sc_a, tc_a, sc_b, tc_b;
    adv_t             col_a, col_b, row_n;
    logic             row_sel, p0, p1;

    always_comb
    begin
        sc   = frame_start ? '0 : source_col_reg;
        sr   = frame_start ? '0 : source_row_reg;
        tc   = frame_start ? '0 : target_col_reg;
        tr   = frame_start ? '0 : target_row_reg;
        npc  = frame_start ? '0 : next_pick_col_reg;
        crem = frame_start ? '0 : col_remainder_reg;
        npr  = frame_start ? '0 : next_pick_row_reg;
        rrem = frame_start ? '0 : row_remainder_reg;

        row_sel = (sr < geom.sh) && (tr < geom.th) && (sr == npr);

        // first pixel of the pgroup
        p0 = row_sel && (sc == npc) && (tc < geom.tw);
        if (p0)
        begin
            col_a = advance(npc, crem, geom.col_q, geom.col_r, geom.tw);
            tc_a  = tc + DIM_W'(1);
        end
        else
        begin
            col_a.pick = npc;
            col_a.rem  = crem;
            tc_a       = tc;
        end
        sc_a = (sc < geom.sw) ? sc + DIM_W'(1) : sc;

        // second pixel
        p1 = row_sel && (sc_a == col_a.pick) && (tc_a < geom.tw);
        if (p1)
        begin
            col_b = advance(col_a.pick, col_a.rem, geom.col_q, geom.col_r, geom.tw);
            tc_b  = tc_a + DIM_W'(1);
        end
        else
        begin
            col_b = col_a;
            tc_b  = tc_a;
        end
        sc_b = (sc_a < geom.sw) ? sc_a + DIM_W'(1) : sc_a;

        row_n = advance(npr, rrem, geom.row_q, geom.row_r, geom.th);

        source_col_next    = sc_b;
        source_row_next    = sr;
        target_col_next    = tc_b;
        target_row_next    = tr;
        next_pick_col_next = col_b.pick;
        col_remainder_next = col_b.rem;
        next_pick_row_next = npr;
        row_remainder_next = rrem;

        // end of source line
        if (sc_b >= geom.sw)
        begin
            source_col_next = '0;
            if (row_sel)
            begin
                target_row_next    = tr + DIM_W'(1);
                next_pick_row_next = row_n.pick;
                row_remainder_next = row_n.rem;
            end
            target_col_next    = '0;
            next_pick_col_next = '0;
            col_remainder_next = '0;
            if (sr < geom.sh)
                source_row_next = sr + DIM_W'(1);
        end

        info.pick    = {p1, p0};
        info.tcol0   = tc[POS_W-1:0];
        info.tcol1   = tc_a[POS_W-1:0];
        info.trow    = tr[POS_W-1:0];
        info.done[0] = (tc == geom.tw - DIM_W'(1)) && (tr == geom.th - DIM_W'(1));
        info.done[1] = (tc_a == geom.tw - DIM_W'(1)) && (tr == geom.th - DIM_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_col_reg    <= '0;
            source_row_reg    <= '0;
            target_col_reg    <= '0;
            target_row_reg    <= '0;
            next_pick_col_reg <= '0;
            col_remainder_reg <= '0;
            next_pick_row_reg <= '0;
            row_remainder_reg <= '0;
        end
        else if (fire)
        begin
            source_col_reg    <= source_col_next;
            source_row_reg    <= source_row_next;
            target_col_reg    <= target_col_next;
            target_row_reg    <= target_row_next;
            next_pick_col_reg <= next_pick_col_next;
            col_remainder_reg <= col_remainder_next;
            next_pick_row_reg <= next_pick_row_next;
            row_remainder_reg <= row_remainder_next;
        end
    end

endmodule

>>> rtl/pdsc_csc.sv
// BT.709 limited-range 10-bit YCbCr to 8-bit RGB for both pixels of a pgroup.
`timescale 1ns / 1ps

module pdsc_csc (
    input  logic                        clk,
    input  logic [pdsc_pkg::SMP_W-1:0]  y0,
    input  logic [pdsc_pkg::SMP_W-1:0]  y1,
    input  logic [pdsc_pkg::SMP_W-1:0]  cb,
    input  logic [pdsc_pkg::SMP_W-1:0]  cr,
    output logic [pdsc_pkg::CHAN_W-1:0] red0,
    output logic [pdsc_pkg::CHAN_W-1:0] green0,
    output logic [pdsc_pkg::CHAN_W-1:0] blue0,
    output logic [pdsc_pkg::CHAN_W-1:0] red1,
    output logic [pdsc_pkg::CHAN_W-1:0] green1,
    output logic [pdsc_pkg::CHAN_W-1:0] blue1
);
    import pdsc_pkg::*;

    logic signed [DIFF_W-1:0] y0_d, y1_d, cb_d, cr_d;
    logic signed [PROD_W-1:0] py0_reg, py1_reg, pr_reg, pgb_reg, pgr_reg, pb_reg;
    logic signed [ACC_W-1:0]  cr_term, cg_term, cb_term;

    assign y0_d = $signed({1'b0, y0}) - Y_OFFSET;
    assign y1_d = $signed({1'b0, y1}) - Y_OFFSET;
    assign cb_d = $signed({1'b0, cb}) - C_OFFSET;
    assign cr_d = $signed({1'b0, cr}) - C_OFFSET;

    always_ff @(posedge clk)
    begin
        py0_reg <= PROD_W'(KY)  * PROD_W'(y0_d);
        py1_reg <= PROD_W'(KY)  * PROD_W'(y1_d);
        pr_reg  <= PROD_W'(KR)  * PROD_W'(cr_d);
        pgb_reg <= PROD_W'(KGB) * PROD_W'(cb_d);
        pgr_reg <= PROD_W'(KGR) * PROD_W'(cr_d);
        pb_reg  <= PROD_W'(KB)  * PROD_W'(cb_d);
    end

    // chroma terms shared by both pixels
    assign cr_term = ACC_W'(pr_reg);
    assign cg_term = -ACC_W'(pgb_reg) - ACC_W'(pgr_reg);
    assign cb_term = ACC_W'(pb_reg);

    assign red0   = to_8bit(ACC_W'(py0_reg) + cr_term);
    assign green0 = to_8bit(ACC_W'(py0_reg) + cg_term);
    assign blue0  = to_8bit(ACC_W'(py0_reg) + cb_term);
    assign red1   = to_8bit(ACC_W'(py1_reg) + cr_term);
    assign green1 = to_8bit(ACC_W'(py1_reg) + cg_term);
    assign blue1  = to_8bit(ACC_W'(py1_reg) + cb_term);

endmodule

>>> rtl/pdsc_ofifo.sv
// Result queue: up to two items in per cycle, one item out.
`timescale 1ns / 1ps

module pdsc_ofifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    push_cnt,
    input  pdsc_pkg::result_t             push_a,
    input  pdsc_pkg::result_t             push_b,
    input  logic                          pop,
    output pdsc_pkg::result_t             head,
    output logic [pdsc_pkg::OFIFO_CW-1:0] count
);
    import pdsc_pkg::*;

    result_t             mem [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OFIFO_CW-1:0] count_reg;
    logic [OFIFO_AW-1:0] wr_ptr_b;

    assign wr_ptr_b = wr_ptr_reg + OFIFO_AW'(1);

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem[wr_ptr_reg] <= push_a;
        if (push_cnt == 2'd2)
            mem[wr_ptr_b] <= push_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + OFIFO_AW'(push_cnt);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + OFIFO_AW'(1);
            count_reg <= count_reg + OFIFO_CW'(push_cnt) - OFIFO_CW'(pop);
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign count = count_reg;

endmodule

>>> rtl/pgroup_downscale_ycbcr_to_rgb_unit.sv
// Top level: 4:2:2 10-bit pgroup stream to nearest-neighbour RGB thumbnail pixels.
// Each result passes through the input, product and queue registers before m_tvalid offers it.
// Throughput: one pgroup per cycle; results leave at up to one per cycle through an
// eight-item queue, so pgroups that pick two pixels hold s_tready low as it fills.
// After reset or a configuration write the dividers load and then shift out the quotient
// bit by bit, with s_tready held low until both finish; a write during a pass queues a fresh one.
`timescale 1ns / 1ps

module pgroup_downscale_ycbcr_to_rgb_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // pgroup[39:0]
    input  logic        s_tuser,   // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // red[7:0], green[15:8], blue[23:16], thumb_col[36:24],
                                   // thumb_row[49:37], zero[55:50]
    output logic        m_tlast,   // last_of_run
    output logic        m_tuser,   // frame_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data
);
    import pdsc_pkg::*;

    geom_t             geom;
    pick_t             pinfo;
    logic              s_fire;
    logic              m_fire;

    logic [1:0]        s1_pick_reg, s2_pick_reg;
    logic [SMP_W-1:0]  s1_y0_reg, s1_y1_reg, s1_cb_reg, s1_cr_reg;
    logic [POS_W-1:0]  s1_tcol0_reg, s1_tcol1_reg, s1_trow_reg;
    logic [POS_W-1:0]  s2_tcol0_reg, s2_tcol1_reg, s2_trow_reg;
    logic [1:0]        s1_done_reg, s2_done_reg;

    logic [CHAN_W-1:0] red0, green0, blue0, red1, green1, blue1;
    result_t           item0, item1, push_a, head;
    logic [1:0]        push_cnt, s1_cnt;
    logic [OFIFO_CW-1:0] fifo_count;
    logic [OFIFO_CW+1:0] reserved;

    assign s1_cnt   = {1'b0, s1_pick_reg[0]} + {1'b0, s1_pick_reg[1]};
    assign push_cnt = {1'b0, s2_pick_reg[0]} + {1'b0, s2_pick_reg[1]};
    assign reserved = (OFIFO_CW+2)'(fifo_count) + (OFIFO_CW+2)'(s1_cnt)
                    + (OFIFO_CW+2)'(push_cnt) + (OFIFO_CW+2)'(2);

    assign s_tready = ~geom.busy && (reserved <= (OFIFO_CW+2)'(OFIFO_DEPTH));
    assign s_fire   = s_tvalid & s_tready;

    pdsc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    pdsc_pick u_pick (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (s_fire),
        .frame_start (s_tuser),
        .geom        (geom),
        .info        (pinfo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_pick_reg <= '0;
            s2_pick_reg <= '0;
        end
        else
        begin
            s1_pick_reg <= s_fire ? pinfo.pick : 2'b00;
            s2_pick_reg <= s1_pick_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_cb_reg    <= s_tdata[39:30];
            s1_y0_reg    <= s_tdata[29:20];
            s1_cr_reg    <= s_tdata[19:10];
            s1_y1_reg    <= s_tdata[9:0];
            s1_tcol0_reg <= pinfo.tcol0;
            s1_tcol1_reg <= pinfo.tcol1;
            s1_trow_reg  <= pinfo.trow;
            s1_done_reg  <= pinfo.done;
        end
        s2_tcol0_reg <= s1_tcol0_reg;
        s2_tcol1_reg <= s1_tcol1_reg;
        s2_trow_reg  <= s1_trow_reg;
        s2_done_reg  <= s1_done_reg;
    end

    pdsc_csc u_csc (
        .clk    (clk),
        .y0     (s1_y0_reg),
        .y1     (s1_y1_reg),
        .cb     (s1_cb_reg),
        .cr     (s1_cr_reg),
        .red0   (red0),
        .green0 (green0),
        .blue0  (blue0),
        .red1   (red1),
        .green1 (green1),
        .blue1  (blue1)
    );

    always_comb
    begin
        item0.red         = red0;
        item0.green       = green0;
        item0.blue        = blue0;
        item0.thumb_col   = s2_tcol0_reg;
        item0.thumb_row   = s2_trow_reg;
        item0.last_of_run = ~s2_pick_reg[1];
        item0.frame_done  = s2_done_reg[0];

        item1.red         = red1;
        item1.green       = green1;
        item1.blue        = blue1;
        item1.thumb_col   = s2_tcol1_reg;
        item1.thumb_row   = s2_trow_reg;
        item1.last_of_run = 1'b1;
        item1.frame_done  = s2_done_reg[1];

        push_a = s2_pick_reg[0] ? item0 : item1;
    end

    assign m_fire = m_tvalid & m_tready;

    pdsc_ofifo u_ofifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .push_a   (push_a),
        .push_b   (item1),
        .pop      (m_fire),
        .head     (head),
        .count    (fifo_count)
    );

    assign m_tvalid = (fifo_count != '0);
    assign m_tdata  = {6'b0, head.thumb_row, head.thumb_col, head.blue, head.green, head.red};
    assign m_tlast  = head.last_of_run;
    assign m_tuser  = head.frame_done;

endmodule
